>>> rtl/lbs_pkg.sv
package lbs_pkg;

   // defaults for the top-level parameters
   localparam int MAX_BONES_DEF = 256;
   localparam int FRAC_BITS_DEF = 16;

   // field widths
   localparam int DATA_W      = 32;
   localparam int WEIGHT_W    = 17;
   localparam int WEIGHT_FRAC = 16;
   localparam int BONE_W      = 8;
   localparam int ELEM_W      = 4;
   localparam int COUNT_W     = 9;
   localparam int ACC_W       = 48;

   // matrix shape: rows 0..3, columns 0..2
   localparam int ELEMS     = 12;
   localparam int ELEM_COLS = 3;
   localparam int ROW_W     = 2;
   localparam int COL_W     = 2;

   // pipeline depth from issue to write-back
   localparam int DRAIN_CYCLES = 2;

   // stream layout of the request channel
   localparam int REQ_DATA_W   = 160;
   localparam int REQ_USER_W   = 2;
   localparam int BONE_LSB     = 0;
   localparam int ELEM_LSB     = 8;
   localparam int VALUE_LSB    = 12;
   localparam int WEIGHT_LSB   = 44;
   localparam int REST_X_LSB   = 61;
   localparam int REST_Y_LSB   = 93;
   localparam int REST_Z_LSB   = 125;
   localparam int USER_CMD_BIT = 0;
   localparam int USER_HAS_BIT = 1;

   // stream layout of the response channel
   localparam int RSP_DATA_W = 96;

   typedef enum logic {
      CMD_WRITE     = 1'b0,
      CMD_INFLUENCE = 1'b1
   } req_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_ACC_DRAIN,
      ST_XFORM,
      ST_XF_DRAIN,
      ST_PUBLISH
   } state_type;

   typedef enum logic {
      OP_ACCUM,
      OP_XFORM
   } op_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic              take;
      logic              issue;
      op_type            op;
      logic [ELEM_W-1:0] elem;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic              publish;
      logic              bypass;
   } ctrl_cmd_type;

endpackage

>>> rtl/lbs_ctrl.sv
module lbs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_cmd,
   input  logic                  req_has_influence,
   input  logic                  req_last,
   input  logic                  out_free,
   output lbs_pkg::ctrl_cmd_type cmd
);

   lbs_pkg::state_type            state_ff, state_in;
   logic [lbs_pkg::ELEM_W-1:0]    cnt_ff, cnt_in;
   logic                          last_ff, last_in;
   logic                          bypass_ff, bypass_in;
   logic [lbs_pkg::ROW_W-1:0]     xf_row;
   logic [lbs_pkg::COL_W-1:0]     xf_col;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lbs_pkg::ST_IDLE;
         cnt_ff    <= '0;
         last_ff   <= 1'b0;
         bypass_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         last_ff   <= last_in;
         bypass_ff <= bypass_in;
      end
   end

   // transform walks column by column, rows 0..3 within a column
   assign xf_row = cnt_ff[lbs_pkg::ROW_W-1:0];
   assign xf_col = cnt_ff[lbs_pkg::ELEM_W-1:lbs_pkg::ROW_W];

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      last_in    = last_ff;
      bypass_in  = bypass_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         lbs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               if (req_cmd == lbs_pkg::CMD_INFLUENCE) begin
                  if (!req_has_influence) begin
                     bypass_in = 1'b1;
                     state_in  = lbs_pkg::ST_PUBLISH;
                  end else begin
                     bypass_in = 1'b0;
                     last_in   = req_last;
                     cnt_in    = '0;
                     state_in  = lbs_pkg::ST_ACCUM;
                  end
               end
            end
         end
         lbs_pkg::ST_ACCUM: begin
            cmd.issue = 1'b1;
            cmd.op    = lbs_pkg::OP_ACCUM;
            cmd.elem  = cnt_ff;
            if (cnt_ff == lbs_pkg::ELEM_W'(lbs_pkg::ELEMS - 1)) begin
               cnt_in   = '0;
               state_in = lbs_pkg::ST_ACC_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         lbs_pkg::ST_ACC_DRAIN: begin
            if (cnt_ff == lbs_pkg::ELEM_W'(lbs_pkg::DRAIN_CYCLES - 1)) begin
               cnt_in   = '0;
               state_in = last_ff ? lbs_pkg::ST_XFORM : lbs_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         lbs_pkg::ST_XFORM: begin
            cmd.issue = 1'b1;
            cmd.op    = lbs_pkg::OP_XFORM;
            cmd.row   = xf_row;
            cmd.col   = xf_col;
            cmd.elem  = lbs_pkg::ELEM_W'(int'(xf_row) * lbs_pkg::ELEM_COLS + int'(xf_col));
            if (cnt_ff == lbs_pkg::ELEM_W'(lbs_pkg::ELEMS - 1)) begin
               cnt_in   = '0;
               state_in = lbs_pkg::ST_XF_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         lbs_pkg::ST_XF_DRAIN: begin
            if (cnt_ff == lbs_pkg::ELEM_W'(lbs_pkg::DRAIN_CYCLES - 1)) begin
               cnt_in   = '0;
               state_in = lbs_pkg::ST_PUBLISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         lbs_pkg::ST_PUBLISH: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               cmd.bypass  = bypass_ff;
               state_in    = lbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lbs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/lbs_dp.sv
module lbs_dp #(
   parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF,
   parameter int FRAC_BITS = lbs_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lbs_pkg::ctrl_cmd_type           cmd,
   output logic                            out_free,
   input  logic [lbs_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [lbs_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lbs_pkg::COUNT_W-1:0]     csr_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lbs_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int NUM_BONES = (MAX_BONES < (1 << lbs_pkg::BONE_W)) ? MAX_BONES
                                                                    : (1 << lbs_pkg::BONE_W);
   localparam int DEPTH     = NUM_BONES * lbs_pkg::ELEMS;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW        = lbs_pkg::DATA_W;
   localparam int AW        = lbs_pkg::ACC_W;
   localparam int B_W       = DW + 1;
   localparam int PROD_W    = DW + B_W;
   localparam int ASUM_W    = AW + 2;
   localparam int SUM_W     = PROD_W + 2 - FRAC_BITS;
   localparam logic signed [DW-1:0]  ONE_A = DW'(1 << FRAC_BITS);
   localparam logic signed [B_W-1:0] ONE_B = B_W'(1 << FRAC_BITS);

   // request fields
   logic [lbs_pkg::BONE_W-1:0]   in_bone;
   logic [lbs_pkg::ELEM_W-1:0]   in_elem;
   logic [DW-1:0]                in_value;
   logic [lbs_pkg::WEIGHT_W-1:0] in_weight;
   logic [DW-1:0]                in_rest_x, in_rest_y, in_rest_z;

   assign in_bone   = req_tdata[lbs_pkg::BONE_LSB +: lbs_pkg::BONE_W];
   assign in_elem   = req_tdata[lbs_pkg::ELEM_LSB +: lbs_pkg::ELEM_W];
   assign in_value  = req_tdata[lbs_pkg::VALUE_LSB +: DW];
   assign in_weight = req_tdata[lbs_pkg::WEIGHT_LSB +: lbs_pkg::WEIGHT_W];
   assign in_rest_x = req_tdata[lbs_pkg::REST_X_LSB +: DW];
   assign in_rest_y = req_tdata[lbs_pkg::REST_Y_LSB +: DW];
   assign in_rest_z = req_tdata[lbs_pkg::REST_Z_LSB +: DW];

   // configuration register
   logic [lbs_pkg::COUNT_W-1:0] palette_count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_count_ff <= '0;
      end else if (csr_valid) begin
         palette_count_ff <= csr_data;
      end
   end

   // captured item
   logic [lbs_pkg::BONE_W-1:0]   bone_ff;
   logic [lbs_pkg::WEIGHT_W-1:0] weight_ff;
   logic [DW-1:0]                rest_x_ff, rest_y_ff, rest_z_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         bone_ff   <= in_bone;
         weight_ff <= in_weight;
         rest_x_ff <= in_rest_x;
         rest_y_ff <= in_rest_y;
         rest_z_ff <= in_rest_z;
      end
   end

   // bone palette, one element per word
   logic [DW-1:0]     palette_mem [DEPTH];
   logic [DW-1:0]     mem_q_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   assign wr_en = cmd.take && (req_tuser[lbs_pkg::USER_CMD_BIT] == lbs_pkg::CMD_WRITE)
                  && (int'(in_elem) < lbs_pkg::ELEMS) && (int'(in_bone) < MAX_BONES);
   assign wr_addr = ADDR_W'(int'(in_bone) * lbs_pkg::ELEMS + int'(in_elem));
   assign rd_addr = ADDR_W'(int'(bone_ff) * lbs_pkg::ELEMS + int'(cmd.elem));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         palette_mem[wr_addr] <= in_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         mem_q_ff <= palette_mem[rd_addr];
      end
   end

   // blend accumulators
   logic signed [AW-1:0] acc_ff [lbs_pkg::ELEMS];
   logic signed [AW-1:0] acc_in;

   // stage 1: operands
   logic                         s1_valid_ff;
   lbs_pkg::op_type              s1_op_ff;
   logic [lbs_pkg::ELEM_W-1:0]   s1_elem_ff;
   logic [lbs_pkg::ROW_W-1:0]    s1_row_ff;
   logic [lbs_pkg::COL_W-1:0]    s1_col_ff;
   logic                         s1_ident_ff;
   logic signed [AW-1:0]         s1_acc_ff;
   logic                         ident_in;

   // a bone outside the valid palette acts as identity
   assign ident_in = !((lbs_pkg::COUNT_W'(bone_ff) < palette_count_ff)
                       && (int'(bone_ff) < MAX_BONES));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         s1_op_ff    <= cmd.op;
         s1_elem_ff  <= cmd.elem;
         s1_row_ff   <= cmd.row;
         s1_col_ff   <= cmd.col;
         s1_ident_ff <= ident_in;
         s1_acc_ff   <= acc_ff[cmd.elem];
      end
   end

   logic signed [DW-1:0]     a_op;
   logic signed [B_W-1:0]    b_op;
   logic signed [PROD_W-1:0] prod_in;
   logic                     acc_fits;

   assign acc_fits = (&s1_acc_ff[AW-1:DW-1]) || (~|s1_acc_ff[AW-1:DW-1]);

   // operand select and the one multiplier
   always_comb begin
      if (s1_op_ff == lbs_pkg::OP_XFORM) begin
         // blended element saturated to 32 bits
         if (acc_fits) begin
            a_op = s1_acc_ff[DW-1:0];
         end else if (s1_acc_ff[AW-1]) begin
            a_op = {1'b1, {(DW-1){1'b0}}};
         end else begin
            a_op = {1'b0, {(DW-1){1'b1}}};
         end
         case (s1_row_ff)
            2'd0:    b_op = {rest_x_ff[DW-1], rest_x_ff};
            2'd1:    b_op = {rest_y_ff[DW-1], rest_y_ff};
            2'd2:    b_op = {rest_z_ff[DW-1], rest_z_ff};
            default: b_op = ONE_B;
         endcase
      end else begin
         // diagonal elements sit at row*4
         if (s1_ident_ff) begin
            a_op = (s1_elem_ff[1:0] == 2'b00) ? ONE_A : '0;
         end else begin
            a_op = mem_q_ff;
         end
         b_op = {{(B_W - lbs_pkg::WEIGHT_W){1'b0}}, weight_ff};
      end
      prod_in = a_op * b_op;
   end

   // stage 2: product and write-back
   logic                       s2_valid_ff;
   lbs_pkg::op_type            s2_op_ff;
   logic [lbs_pkg::ELEM_W-1:0] s2_elem_ff;
   logic [lbs_pkg::ROW_W-1:0]  s2_row_ff;
   logic [lbs_pkg::COL_W-1:0]  s2_col_ff;
   logic signed [AW-1:0]       s2_acc_ff;
   logic signed [PROD_W-1:0]   prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_op_ff   <= s1_op_ff;
         s2_elem_ff <= s1_elem_ff;
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
         s2_acc_ff  <= s1_acc_ff;
         prod_ff    <= prod_in;
      end
   end

   // weighted element added into its accumulator, saturating at 48 bits
   logic signed [PROD_W-1:0] wshift;
   logic signed [ASUM_W-1:0] acc_sum;

   assign wshift  = prod_ff >>> lbs_pkg::WEIGHT_FRAC;
   assign acc_sum = {{(ASUM_W - AW){s2_acc_ff[AW-1]}}, s2_acc_ff} + wshift[ASUM_W-1:0];

   always_comb begin
      if ((&acc_sum[ASUM_W-1:AW-1]) || (~|acc_sum[ASUM_W-1:AW-1])) begin
         acc_in = acc_sum[AW-1:0];
      end else if (acc_sum[ASUM_W-1]) begin
         acc_in = {1'b1, {(AW-1){1'b0}}};
      end else begin
         acc_in = {1'b0, {(AW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lbs_pkg::ELEMS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (cmd.publish) begin
         for (int i = 0; i < lbs_pkg::ELEMS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (s2_valid_ff && (s2_op_ff == lbs_pkg::OP_ACCUM)) begin
         acc_ff[s2_elem_ff] <= acc_in;
      end
   end

   // column sum of the transform
   logic signed [PROD_W-1:0] xshift;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [DW-1:0]            pos_in;
   logic [DW-1:0]            pos_ff [lbs_pkg::ELEM_COLS];

   assign xshift = prod_ff >>> FRAC_BITS;
   assign sum_in = ((s2_row_ff == '0) ? '0 : sum_ff) + xshift[SUM_W-1:0];

   always_comb begin
      if ((&sum_in[SUM_W-1:DW-1]) || (~|sum_in[SUM_W-1:DW-1])) begin
         pos_in = sum_in[DW-1:0];
      end else if (sum_in[SUM_W-1]) begin
         pos_in = {1'b1, {(DW-1){1'b0}}};
      end else begin
         pos_in = {1'b0, {(DW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && (s2_op_ff == lbs_pkg::OP_XFORM)) begin
         sum_ff <= sum_in;
         if (s2_row_ff == lbs_pkg::ROW_W'(lbs_pkg::ELEM_COLS)) begin
            pos_ff[s2_col_ff] <= pos_in;
         end
      end
   end

   // output register
   logic                          rsp_valid_ff;
   logic [lbs_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         if (cmd.bypass) begin
            rsp_data_ff <= {rest_z_ff, rest_y_ff, rest_x_ff};
         end else begin
            rsp_data_ff <= {pos_ff[2], pos_ff[1], pos_ff[0]};
         end
      end
   end

endmodule

>>> rtl/linear_blend_skinning.sv
// palette write: accepted in the idle state, no result
// influence item: one palette word and one 32x33 multiply per cycle
//   over 12 elements, after the accept cycle and followed by a pipeline drain
// last influence: 12 more multiplies for the transform and a drain, then the result is loaded;
//   the next accept comes in the cycle after the publish; a full output register stalls it
// vertex with no influence: the rest position is published as the result, with no multiplies
// reset: synchronous, clears control, accumulators and palette_count; palette keeps its contents
module linear_blend_skinning #(
   parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF,
   parameter int FRAC_BITS = lbs_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // bone_index, element_index, element_value, weight, rest_x, rest_y, rest_z, zero pad
   input  logic [lbs_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd, has_influence
   input  logic [lbs_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pos_x, pos_y, pos_z
   output logic [lbs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lbs_pkg::COUNT_W-1:0]     csr_data
);

   lbs_pkg::ctrl_cmd_type ctrl_cmd;
   logic                  out_free;

   // sequencer
   lbs_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_cmd           (req_tuser[lbs_pkg::USER_CMD_BIT]),
      .req_has_influence (req_tuser[lbs_pkg::USER_HAS_BIT]),
      .req_last          (req_tlast),
      .out_free          (out_free),
      .cmd               (ctrl_cmd)
   );

   // palette, multiplier and accumulators
   lbs_dp #(
      .MAX_BONES (MAX_BONES),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ctrl_cmd),
      .out_free   (out_free),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // no new transaction while the pipeline is issuing
   a_issue_blocks_req: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.issue |-> !req_tready)
      else $error("pipeline issue while request channel ready");

   // a result is only loaded into a free output register
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.publish |-> out_free)
      else $error("result published over a pending response");

   // a published result appears on the response channel
   a_publish_shows: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.publish |=> rsp_tvalid)
      else $error("published result missing on response channel");

   // capture only on an accepted transaction
   a_take_accept: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.take |-> (req_tvalid && req_tready))
      else $error("item captured without a request transaction");

endmodule
